// File: hw/rtl/mczr_pkg.sv
// ----------------------------------------------------------------------------
// mczr_pkg
// shared types, register indexes and defaults of the zero-order-hold resampler
// ----------------------------------------------------------------------------
package mczr_pkg;

  localparam int CHANNELS_DEF        = 4;
  localparam int FRAMES_PER_ITEM_DEF = 16;
  localparam int VALUE_BITS_DEF      = 32;

  localparam int CH_FIELD_BITS    = 2;
  localparam int SAMPLE_BITS      = 32;
  localparam int TIME_BITS        = 63;
  localparam int CFG_DATA_BITS    = 32;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CHANS_CFG_BITS   = 3;
  localparam int TDATA_BITS       = 104;
  localparam int TUSER_BITS       = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_PERIOD   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DROP_MODE       = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNELS_IN_USE = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0]  PERIOD_RESET = 32'd1000000;
  localparam logic [CHANS_CFG_BITS-1:0] CHANS_RESET  = 3'd4;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic                     frame_last;
    logic                     underrun;
    logic [TIME_BITS-1:0]     frame_time;
    logic [SAMPLE_BITS-1:0]   value;
    logic [CH_FIELD_BITS-1:0] out_channel;
  } result_t;

endpackage

// File: hw/rtl/mczr_ram.sv
// ----------------------------------------------------------------------------
// mczr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mczr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/multichannel_zoh_resampler.sv
// ----------------------------------------------------------------------------
// multichannel_zoh_resampler
// zero-order-hold resampler: holds the newest word per channel and emits
// frames of all active channels at a fixed period on group ends
//
//   port group   dir  payload                                   marker
//   s_*          in   channel, sample_value, sample_time        tlast = group_end
//   m_*          out  out_channel, value, frame_time            tlast = run_last
//   cfg_*        in   output_period, drop_mode, channels_in_use  -
//
// an item without group end is taken while idle; a group end runs ST_FRAME per
// examined frame, ST_CHK_RD/ST_CHK_EV per channel checked in drop mode and
// ST_EMIT_RD/ST_EMIT_WR per word emitted, as the hold memory has one read port
// reset clears channel valid flags and timing at once, no clearing pass
// a stalled m side holds the emit loop; s_tready is high only when idle
// ----------------------------------------------------------------------------
module multichannel_zoh_resampler #(
  parameter int CHANNELS        = mczr_pkg::CHANNELS_DEF,
  parameter int FRAMES_PER_ITEM = mczr_pkg::FRAMES_PER_ITEM_DEF,
  parameter int VALUE_BITS      = mczr_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // channel, sample_value, sample_time
  input  logic [mczr_pkg::TDATA_BITS-1:0]     s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // out_channel, value, frame_time
  output logic [mczr_pkg::TDATA_BITS-1:0]     m_tdata,
  // underrun, frame_last
  output logic [mczr_pkg::TUSER_BITS-1:0]     m_tuser,
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [mczr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mczr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int TB     = mczr_pkg::TIME_BITS;
  localparam int CH_B   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int N_B    = $clog2(CHANNELS + 1);
  localparam int SLOT_B = $clog2(FRAMES_PER_ITEM + 1);
  localparam int MEM_W  = VALUE_BITS + TB;

  // configuration
  logic [mczr_pkg::CFG_DATA_BITS-1:0]  output_period;
  logic                                drop_mode;
  logic [mczr_pkg::CHANS_CFG_BITS-1:0] channels_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_period   <= mczr_pkg::PERIOD_RESET;
      drop_mode       <= 1'b0;
      channels_in_use <= mczr_pkg::CHANS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mczr_pkg::CFG_OUTPUT_PERIOD:   output_period   <= cfg_data;
        mczr_pkg::CFG_DROP_MODE:       drop_mode       <= cfg_data[0];
        mczr_pkg::CFG_CHANNELS_IN_USE: channels_in_use <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [N_B-1:0]                     n_active;
  logic [mczr_pkg::CFG_DATA_BITS-1:0] period_eff;

  always_comb begin
    if (channels_in_use == '0) begin
      n_active = N_B'(1);
    end else if (32'(channels_in_use) > 32'(CHANNELS)) begin
      n_active = N_B'(CHANNELS);
    end else begin
      n_active = N_B'(channels_in_use);
    end
    period_eff = (output_period == '0) ? 32'd1 : output_period;
  end

  // input fields
  logic [mczr_pkg::CH_FIELD_BITS-1:0] in_ch;
  logic [mczr_pkg::SAMPLE_BITS-1:0]   in_value;
  logic [TB-1:0]                      in_time;
  logic                               accept;
  logic                               in_store;

  assign in_ch    = s_tdata[1:0];
  assign in_value = s_tdata[33:2];
  assign in_time  = s_tdata[96:34];
  assign accept   = s_tvalid && s_tready;
  assign in_store = {30'd0, in_ch} < 32'(CHANNELS);

  // control state
  mczr_pkg::state_t    state, state_next;
  logic [CH_B-1:0]     cidx;
  logic [SLOT_B-1:0]   slots;
  logic [CHANNELS-1:0] loaded;
  logic [TB-1:0]       next_frame_time;
  logic                timing_started;
  logic [TB-1:0]       group_max_time;
  logic                group_seen;

  // hold memory: value and time per channel
  logic [MEM_W-1:0] rd_word;
  logic [VALUE_BITS-1:0] rd_value;
  logic [TB-1:0]         rd_time;

  mczr_ram #(
    .WIDTH(MEM_W),
    .DEPTH(CHANNELS)
  ) u_hold (
    .clk  (clk),
    .we   (accept && in_store),
    .waddr(CH_B'(in_ch)),
    .wdata({VALUE_BITS'(in_value), in_time}),
    .raddr(cidx),
    .rdata(rd_word)
  );

  assign rd_value = rd_word[MEM_W-1:TB];
  assign rd_time  = rd_word[TB-1:0];

  // result staging: pend holds the newest word until its run_last is known
  mczr_pkg::result_t pend;
  logic              pend_valid;
  mczr_pkg::result_t out_res;
  logic              out_last;
  logic              out_free;

  assign out_free = !m_tvalid || m_tready;

  // control decode
  logic          frame_go;
  logic          c_last;
  logic          chk_ok;
  logic          emit_go;
  logic          flush_go;
  logic          out_load;
  logic [TB:0]   adv_sum;
  logic [TB-1:0] adv_time;

  always_comb begin
    frame_go = (32'(slots) < 32'(FRAMES_PER_ITEM)) && (next_frame_time <= group_max_time);
    c_last   = (N_B'(cidx) + N_B'(1)) == n_active;
    chk_ok   = loaded[cidx] && !(rd_time < next_frame_time);
    emit_go  = !pend_valid || out_free;
    flush_go = !pend_valid || out_free;
    out_load = pend_valid && ((state == mczr_pkg::ST_EMIT_WR && emit_go) ||
                              (state == mczr_pkg::ST_FLUSH && out_free));
    adv_sum  = {1'b0, next_frame_time} + {32'd0, period_eff};
    adv_time = adv_sum[TB] ? mczr_pkg::TIME_MAX : adv_sum[TB-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      mczr_pkg::ST_IDLE: begin
        if (accept && s_tlast) state_next = mczr_pkg::ST_FRAME;
      end
      mczr_pkg::ST_FRAME: begin
        if (!frame_go) state_next = mczr_pkg::ST_FLUSH;
        else if (drop_mode) state_next = mczr_pkg::ST_CHK_RD;
        else state_next = mczr_pkg::ST_EMIT_RD;
      end
      mczr_pkg::ST_CHK_RD: state_next = mczr_pkg::ST_CHK_EV;
      mczr_pkg::ST_CHK_EV: begin
        if (!chk_ok) state_next = mczr_pkg::ST_FRAME;
        else if (c_last) state_next = mczr_pkg::ST_EMIT_RD;
        else state_next = mczr_pkg::ST_CHK_RD;
      end
      mczr_pkg::ST_EMIT_RD: state_next = mczr_pkg::ST_EMIT_WR;
      mczr_pkg::ST_EMIT_WR: begin
        if (emit_go) begin
          state_next = c_last ? mczr_pkg::ST_FRAME : mczr_pkg::ST_EMIT_RD;
        end
      end
      mczr_pkg::ST_FLUSH: begin
        if (flush_go) state_next = mczr_pkg::ST_IDLE;
      end
      default: state_next = mczr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == mczr_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mczr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame timing and group tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      cidx            <= '0;
      slots           <= '0;
      loaded          <= '0;
      next_frame_time <= '0;
      timing_started  <= 1'b0;
      group_max_time  <= '0;
      group_seen      <= 1'b0;
    end else begin
      if (accept) begin
        if (!timing_started) begin
          next_frame_time <= in_time;
          timing_started  <= 1'b1;
        end
        if (in_store) loaded[CH_B'(in_ch)] <= 1'b1;
        if (!group_seen || in_time > group_max_time) begin
          group_max_time <= in_time;
          group_seen     <= 1'b1;
        end
        slots <= '0;
      end
      case (state)
        mczr_pkg::ST_FRAME: begin
          cidx <= '0;
          if (frame_go) begin
            slots <= slots + SLOT_B'(1);
          end else begin
            group_max_time <= '0;
            group_seen     <= 1'b0;
          end
        end
        mczr_pkg::ST_CHK_EV: begin
          if (!chk_ok) begin
            next_frame_time <= adv_time;
          end else if (c_last) begin
            cidx <= '0;
          end else begin
            cidx <= cidx + CH_B'(1);
          end
        end
        mczr_pkg::ST_EMIT_WR: begin
          if (emit_go) begin
            if (c_last) begin
              cidx            <= '0;
              next_frame_time <= adv_time;
            end else begin
              cidx <= cidx + CH_B'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result staging and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (state == mczr_pkg::ST_EMIT_WR && emit_go) begin
        pend_valid <= 1'b1;
      end else if (state == mczr_pkg::ST_FLUSH && out_free) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mczr_pkg::ST_EMIT_WR && emit_go) begin
      pend.out_channel <= mczr_pkg::CH_FIELD_BITS'(cidx);
      pend.value       <= loaded[cidx] ? mczr_pkg::SAMPLE_BITS'(rd_value) : '0;
      pend.frame_time  <= next_frame_time;
      pend.underrun    <= !loaded[cidx];
      pend.frame_last  <= c_last;
      if (pend_valid) begin
        out_res  <= pend;
        out_last <= 1'b0;
      end
    end else if (state == mczr_pkg::ST_FLUSH && pend_valid && out_free) begin
      out_res  <= pend;
      out_last <= 1'b1;
    end
  end

  assign m_tdata = {7'd0, out_res.frame_time, out_res.value, out_res.out_channel};
  assign m_tuser = {out_res.frame_last, out_res.underrun};
  assign m_tlast = out_last;

  // checks
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == mczr_pkg::ST_IDLE) |-> !pend_valid)
    else $error("staged word left behind when idle");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    32'(slots) <= 32'(FRAMES_PER_ITEM))
    else $error("frame budget exceeded");

  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    (state == mczr_pkg::ST_EMIT_WR && pend_valid && !out_free) |=> $stable(pend))
    else $error("staged word overwritten while output stalled");

  a_frame_time_mono: assert property (@(posedge clk) disable iff (rst)
    (timing_started && !accept && $past(timing_started) && !$past(accept))
      |-> (next_frame_time >= $past(next_frame_time)))
    else $error("frame time moved backward");

endmodule
